// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/mprm_pkg.sv =====
// Types, constants and helpers of the pulse rate monitor.
`default_nettype none

package mprm_pkg;

    localparam int CHAN_W    = 4;
    localparam int STAMP_W   = 32;
    localparam int VAL_W     = 16;
    localparam int CLK_HZ_W  = 31;
    localparam int PRE_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TIMER_W   = 17;
    localparam int QUO_W     = CLK_HZ_W;
    localparam int DIVISOR_W = PRE_W + 1 + STAMP_W;
    localparam int RATE_IN_W = 10;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_PULSE  = 1'b1;
    localparam logic KIND_RATE  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT   = 3'd4;

    localparam logic [CLK_HZ_W-1:0] RST_CLOCK_HZ     = 31'd100000000;
    localparam logic [PRE_W-1:0]    RST_PRESCALE     = 16'd99;
    localparam logic [VAL_W-1:0]    RST_RATE_PERIOD  = 16'd300;
    localparam logic [VAL_W-1:0]    RST_COUNT_PERIOD = 16'd300;
    localparam logic [VAL_W-1:0]    RST_IDLE_LIMIT   = 16'd500;

    localparam logic [QUO_W-1:0] RATE_SAT_LIMIT = 31'd655;
    localparam logic [VAL_W-1:0] RATE_SCALE     = 16'd100;
    localparam logic [VAL_W-1:0] VAL_MAX        = 16'hFFFF;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [VAL_W-1:0]   rate;
        logic [VAL_W-1:0]   count;
        logic [VAL_W-1:0]   idle;
    } chan_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREAD,
        S_PMUL,
        S_PDIV,
        S_PWRITE,
        S_SREAD,
        S_SPROC,
        S_CREAD,
        S_CPROC
    } seq_state_t;

    typedef struct packed {
        logic                 start;
        logic [CLK_HZ_W-1:0]  dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    // rate * 100, saturated to 16 bits
    function automatic logic [VAL_W-1:0] scale_rate(input logic [QUO_W-1:0] q);
        logic [VAL_W-1:0] r;
        if (q > RATE_SAT_LIMIT) begin
            r = VAL_MAX;
        end else begin
            r = VAL_W'(q[RATE_IN_W-1:0]) * RATE_SCALE;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mprm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module mprm_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/mprm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module mprm_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mprm_pkg::div_req_t req,
    output mprm_pkg::div_rsp_t     rsp
);

    localparam int QW    = mprm_pkg::QUO_W;
    localparam int DW    = mprm_pkg::DIVISOR_W;
    localparam int STEPW = $clog2(QW + 1);

    logic             busy_reg;
    logic [STEPW-1:0] cnt_reg;
    logic [QW-1:0]    num_reg;
    logic [DW-1:0]    den_reg;
    logic [QW-1:0]    rem_reg;
    logic [QW-1:0]    quo_reg;

    logic [QW:0]      rem_shift;
    logic [DW-1:0]    diff;
    logic             fits;
    logic [QW-1:0]    rem_next;

    always_comb begin
        rem_shift = {rem_reg, num_reg[QW-1]};
        fits      = DW'(rem_shift) >= den_reg;
        diff      = DW'(rem_shift) - den_reg;
        rem_next  = fits ? diff[QW-1:0] : rem_shift[QW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= STEPW'(QW);
        end else if (busy_reg) begin
            busy_reg <= (cnt_reg != STEPW'(1));
            cnt_reg  <= cnt_reg - STEPW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[QW-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/multichannel_pulse_rate_monitor_top.sv =====
// Top level of the multichannel pulse rate monitor.
// Usage:
//   s_* channel: one item per transfer; s_cmd selects a 1 ms tick or a pulse
//   (s_channel, s_timestamp). s_ready is high only while the block is idle.
//   m_* channel: report entries, rate runs first, then count runs, each run
//   CHANNELS entries long with m_last on the final one.
//   cfg_* channel: register writes, always ready; index 0..4, others dropped.
// Sequence, one item at a time: a pulse is accepted, then its entry is read,
//   the interval multiplied, the quotient found in 31 divider steps and the
//   entry written back, then the channel sweep follows; a zero interval skips
//   the divider. A tick is accepted and goes straight to the sweep. The sweep
//   does one RAM read and one write-back per channel, and a count run adds a
//   further pass that reads each entry, emits its count and clears it.
// Reset clears all channel state at once through per-entry valid flags and
// restores the register defaults; no clearing pass. When the receiver stalls,
// the single output register holds its entry and a sweep that emits waits on it.
`default_nettype none

module multichannel_pulse_rate_monitor_top #(
    parameter int CHANNELS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [3:0]  s_channel,
    input  wire logic [31:0] s_timestamp,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_report_kind,
    output logic [3:0]       m_sensor_id,
    output logic [15:0]      m_value,
    output logic             m_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);

    localparam int IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW  = mprm_pkg::CHAN_W;
    localparam int VW  = mprm_pkg::VAL_W;
    localparam int TW  = mprm_pkg::TIMER_W;
    localparam int SW  = mprm_pkg::STAMP_W;
    localparam int PW  = mprm_pkg::PRE_W;
    localparam int DW  = mprm_pkg::DIVISOR_W;
    localparam int EW  = $bits(mprm_pkg::chan_entry_t);

    // configuration
    logic [mprm_pkg::CLK_HZ_W-1:0] clock_hz_reg;
    logic [PW-1:0]                 prescale_reg;
    logic [VW-1:0]                 rate_period_reg;
    logic [VW-1:0]                 count_period_reg;
    logic [VW-1:0]                 idle_limit_reg;

    // control
    mprm_pkg::seq_state_t state_reg, state_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [CHANNELS-1:0]  valid_reg;
    logic [TW-1:0]        rate_timer_reg;
    logic [TW-1:0]        count_timer_reg;
    logic                 tick_reg;
    logic                 rate_fire_reg;
    logic                 count_fire_reg;
    logic                 m_valid_reg;

    // payload
    logic [SW-1:0]        stamp_reg;
    logic [VW-1:0]        cnt_reg;
    logic                 zero_reg;
    logic                 m_kind_reg;
    logic [CW-1:0]        m_id_reg;
    logic [VW-1:0]        m_value_reg;
    logic                 m_last_reg;

    // datapath
    logic                 s_accept;
    logic [IW+CW-1:0]     ch_wide;
    logic                 ch_ok;
    logic                 pulse_go;
    logic                 is_tick;
    logic                 rate_t_inc, count_t_inc;
    logic [TW-1:0]        rate_t_new, count_t_new;
    logic                 rate_fire_now, count_fire_now;

    logic [EW-1:0]        ram_rdata;
    logic [EW-1:0]        ram_wdata;
    logic                 ram_we;
    mprm_pkg::chan_entry_t entry, wentry;
    logic [SW-1:0]        delta;
    logic                 delta_zero;
    logic [PW:0]          pre_plus1;
    logic [TW-1:0]        cap_wide;
    logic [VW-1:0]        idle_cap;
    logic [VW-1:0]        idle_new;
    logic [VW-1:0]        rate_new;
    logic [IW+CW-1:0]     idx_wide;
    logic                 idx_last;
    logic                 out_free;
    logic                 proceed;
    logic                 emit_load;
    logic                 emit_kind;
    logic [VW-1:0]        emit_value;

    mprm_pkg::div_req_t   div_req;
    mprm_pkg::div_rsp_t   div_rsp;

    assign s_ready   = (state_reg == mprm_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        ch_wide        = (IW + CW)'(s_channel);
        ch_ok          = ch_wide < (IW + CW)'(CHANNELS);
        is_tick        = (s_cmd == mprm_pkg::CMD_TICK);
        pulse_go       = (s_cmd == mprm_pkg::CMD_PULSE) && ch_ok;
        rate_t_inc     = is_tick && (rate_timer_reg < TW'(rate_period_reg) + TW'(2));
        count_t_inc    = is_tick && (count_timer_reg < TW'(count_period_reg) + TW'(2));
        rate_t_new     = rate_t_inc ? rate_timer_reg + TW'(1) : rate_timer_reg;
        count_t_new    = count_t_inc ? count_timer_reg + TW'(1) : count_timer_reg;
        rate_fire_now  = rate_t_new > TW'(rate_period_reg);
        count_fire_now = count_t_new > TW'(count_period_reg);
    end

    always_comb begin
        entry      = valid_reg[idx_reg] ? mprm_pkg::chan_entry_t'(ram_rdata) : '0;
        delta      = stamp_reg - entry.stamp;
        delta_zero = (delta == '0);
        pre_plus1  = (PW + 1)'(prescale_reg) + (PW + 1)'(1);
        cap_wide   = TW'(idle_limit_reg) + TW'(2);
        idle_cap   = (cap_wide > TW'(mprm_pkg::VAL_MAX)) ? mprm_pkg::VAL_MAX
                                                         : cap_wide[VW-1:0];
        idle_new   = (tick_reg && (entry.idle < idle_cap)) ? entry.idle + VW'(1)
                                                           : entry.idle;
        rate_new   = (idle_new > idle_limit_reg) ? '0 : entry.rate;
        idx_wide   = (IW + CW)'(idx_reg);
        idx_last   = (idx_reg == IW'(CHANNELS - 1));
        out_free   = !m_valid_reg || m_ready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            mprm_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = pulse_go ? mprm_pkg::S_PREAD : mprm_pkg::S_SREAD;
                    idx_next   = pulse_go ? ch_wide[IW-1:0] : '0;
                end
            end
            mprm_pkg::S_PREAD: state_next = mprm_pkg::S_PMUL;
            mprm_pkg::S_PMUL: begin
                state_next = delta_zero ? mprm_pkg::S_PWRITE : mprm_pkg::S_PDIV;
            end
            mprm_pkg::S_PDIV: begin
                if (!div_rsp.busy) begin
                    state_next = mprm_pkg::S_PWRITE;
                end
            end
            mprm_pkg::S_PWRITE: begin
                state_next = mprm_pkg::S_SREAD;
                idx_next   = '0;
            end
            mprm_pkg::S_SREAD: state_next = mprm_pkg::S_SPROC;
            mprm_pkg::S_SPROC: begin
                if (!rate_fire_reg || out_free) begin
                    if (idx_last) begin
                        state_next = count_fire_reg ? mprm_pkg::S_CREAD : mprm_pkg::S_IDLE;
                        idx_next   = '0;
                    end else begin
                        state_next = mprm_pkg::S_SREAD;
                        idx_next   = idx_reg + IW'(1);
                    end
                end
            end
            mprm_pkg::S_CREAD: state_next = mprm_pkg::S_CPROC;
            mprm_pkg::S_CPROC: begin
                if (out_free) begin
                    if (idx_last) begin
                        state_next = mprm_pkg::S_IDLE;
                        idx_next   = '0;
                    end else begin
                        state_next = mprm_pkg::S_CREAD;
                        idx_next   = idx_reg + IW'(1);
                    end
                end
            end
            default: begin
                state_next = mprm_pkg::S_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        ram_we           = 1'b0;
        wentry           = entry;
        proceed          = 1'b0;
        emit_load        = 1'b0;
        emit_kind        = mprm_pkg::KIND_RATE;
        emit_value       = entry.rate;
        div_req.start    = 1'b0;
        div_req.dividend = clock_hz_reg;
        div_req.divisor  = DW'(pre_plus1) * DW'(delta);
        unique case (state_reg)
            mprm_pkg::S_PMUL: begin
                div_req.start = !delta_zero;
            end
            mprm_pkg::S_PWRITE: begin
                ram_we       = 1'b1;
                wentry.stamp = stamp_reg;
                wentry.rate  = zero_reg ? '0 : mprm_pkg::scale_rate(div_rsp.quotient);
                wentry.count = cnt_reg;
                wentry.idle  = '0;
            end
            mprm_pkg::S_SPROC: begin
                proceed     = !rate_fire_reg || out_free;
                ram_we      = proceed;
                wentry.rate = rate_new;
                wentry.idle = idle_new;
                emit_load   = rate_fire_reg && proceed;
                emit_kind   = mprm_pkg::KIND_RATE;
                emit_value  = rate_new;
            end
            mprm_pkg::S_CPROC: begin
                proceed      = out_free;
                ram_we       = out_free;
                wentry.count = '0;
                emit_load    = out_free;
                emit_kind    = mprm_pkg::KIND_COUNT;
                emit_value   = entry.count;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        ram_wdata = wentry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= mprm_pkg::S_IDLE;
            idx_reg          <= '0;
            valid_reg        <= '0;
            rate_timer_reg   <= '0;
            count_timer_reg  <= '0;
            tick_reg         <= 1'b0;
            rate_fire_reg    <= 1'b0;
            count_fire_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
            clock_hz_reg     <= mprm_pkg::RST_CLOCK_HZ;
            prescale_reg     <= mprm_pkg::RST_PRESCALE;
            rate_period_reg  <= mprm_pkg::RST_RATE_PERIOD;
            count_period_reg <= mprm_pkg::RST_COUNT_PERIOD;
            idle_limit_reg   <= mprm_pkg::RST_IDLE_LIMIT;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (ram_we) begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (s_accept) begin
                tick_reg        <= is_tick;
                rate_fire_reg   <= rate_fire_now;
                count_fire_reg  <= count_fire_now;
                rate_timer_reg  <= rate_fire_now ? '0 : rate_t_new;
                count_timer_reg <= count_fire_now ? '0 : count_t_new;
            end
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    mprm_pkg::REG_CLOCK_HZ:     clock_hz_reg     <= cfg_data;
                    mprm_pkg::REG_PRESCALE:     prescale_reg     <= cfg_data[PW-1:0];
                    mprm_pkg::REG_RATE_PERIOD:  rate_period_reg  <= cfg_data[VW-1:0];
                    mprm_pkg::REG_COUNT_PERIOD: count_period_reg <= cfg_data[VW-1:0];
                    mprm_pkg::REG_IDLE_LIMIT:   idle_limit_reg   <= cfg_data[VW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stamp_reg <= s_timestamp;
        end
        if (state_reg == mprm_pkg::S_PMUL) begin
            cnt_reg  <= entry.count + VW'(1);
            zero_reg <= delta_zero;
        end
        if (emit_load) begin
            m_kind_reg  <= emit_kind;
            m_id_reg    <= idx_wide[CW-1:0];
            m_value_reg <= emit_value;
            m_last_reg  <= idx_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_report_kind = m_kind_reg;
    assign m_sensor_id   = m_id_reg;
    assign m_value       = m_value_reg;
    assign m_last        = m_last_reg;

    mprm_ram #(
        .WIDTH (EW),
        .DEPTH (CHANNELS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    mprm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule

`default_nettype wire

// ===== sv/mprm_checker.sv =====
// Port-level checker for the pulse rate monitor, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mprm_checker #(
    parameter int CHANNELS = 16
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_report_kind,
    input wire logic [3:0]  m_sensor_id,
    input wire logic [15:0] m_value,
    input wire logic        m_last
);

    // stalled transfer keeps its entry
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value) && $stable(m_sensor_id) && $stable(m_last) && $stable(m_report_kind))

    // an accepted item makes the block busy in the next cycle
    `ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a run in progress blocks new input
    `ASSERT_IMP(a_run_blocks_input, aclk, aresetn, m_valid && !m_last, !s_ready)

    // the final entry of a run belongs to the highest channel
    `ASSERT_IMP(a_last_id, aclk, aresetn, m_valid && m_last, m_sensor_id == 4'(CHANNELS - 1))

endmodule

bind multichannel_pulse_rate_monitor_top mprm_checker #(
    .CHANNELS (CHANNELS)
) u_mprm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_report_kind (m_report_kind),
    .m_sensor_id   (m_sensor_id),
    .m_value       (m_value),
    .m_last        (m_last)
);

`default_nettype wire
